/* hdl/trgrt_pkg.sv */
`default_nettype none

package trgrt_pkg;

  localparam int GROUP_W  = 8;
  localparam int VERTEX_W = 32;
  localparam int VEND_W   = 33;
  localparam int INDEX_W  = 26;

  typedef struct packed {
    logic [GROUP_W-1:0]  range_group;
    logic [VERTEX_W-1:0] vertex_low;
    logic [VEND_W-1:0]   vertex_end;
    logic [INDEX_W-1:0]  index_first;
    logic [INDEX_W-1:0]  index_end;
    logic                record_valid;
    logic                done_res;
  } rng_t;

  typedef struct packed {
    logic [1:0] push_n;
    rng_t       entry0;
    rng_t       entry1;
  } push_t;

endpackage

`default_nettype wire

/* hdl/trgrt_tri_if.sv */
`default_nettype none

interface trgrt_tri_if import trgrt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [GROUP_W-1:0]  group_id;
  logic [VERTEX_W-1:0] vertex_a;
  logic [VERTEX_W-1:0] vertex_b;
  logic [VERTEX_W-1:0] vertex_c;
  logic                mesh_end;

  modport source (
    output valid, group_id, vertex_a, vertex_b, vertex_c, mesh_end,
    input  ready
  );

  modport sink (
    input  valid, group_id, vertex_a, vertex_b, vertex_c, mesh_end,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/trgrt_rng_if.sv */
`default_nettype none

interface trgrt_rng_if import trgrt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [GROUP_W-1:0]  range_group;
  logic [VERTEX_W-1:0] vertex_low;
  logic [VEND_W-1:0]   vertex_end;
  logic [INDEX_W-1:0]  index_first;
  logic [INDEX_W-1:0]  index_end;
  logic                record_valid;
  logic                done_res;

  modport source (
    output valid, range_group, vertex_low, vertex_end, index_first, index_end,
           record_valid, done_res,
    input  ready
  );

  modport sink (
    input  valid, range_group, vertex_low, vertex_end, index_first, index_end,
           record_valid, done_res,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/trgrt_lane.sv */
`default_nettype none

module trgrt_lane import trgrt_pkg::*; (
  input  logic [VERTEX_W-1:0] vertex,
  input  logic [VERTEX_W-1:0] base_min,
  input  logic [VERTEX_W-1:0] base_max,
  output logic [VERTEX_W-1:0] lo,
  output logic [VERTEX_W-1:0] hi
);

  assign lo = (vertex < base_min) ? vertex : base_min;
  assign hi = (vertex > base_max) ? vertex : base_max;

endmodule

`default_nettype wire

/* hdl/trgrt_track.sv */
`default_nettype none

module trgrt_track import trgrt_pkg::*; #(
  parameter int GROUP_BITS     = 8,
  parameter int TRI_COUNT_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [GROUP_W-1:0]  group_id,
  input  logic [VERTEX_W-1:0] vertex_a,
  input  logic [VERTEX_W-1:0] vertex_b,
  input  logic [VERTEX_W-1:0] vertex_c,
  input  logic                mesh_end,
  output push_t               push
);

  localparam int GW    = (GROUP_BITS < GROUP_W) ? GROUP_BITS : GROUP_W;
  localparam int SLOTS = 1 << GW;
  localparam int PW    = TRI_COUNT_BITS + 1;
  localparam logic [PW-1:0] POS_BOUND = {1'b1, {TRI_COUNT_BITS{1'b0}}};

  logic [GW-1:0]       open_group;
  logic                segment_open;
  logic [PW-1:0]       segment_start;
  logic [PW-1:0]       position;
  logic [VERTEX_W-1:0] span_min;
  logic [VERTEX_W-1:0] span_max;
  logic [SLOTS-1:0]    seen;

  logic [GW-1:0]       g;
  logic                changed;
  logic                cont;
  logic [VERTEX_W-1:0] base_min;
  logic [VERTEX_W-1:0] base_max;
  logic [VERTEX_W-1:0] lo [3];
  logic [VERTEX_W-1:0] hi [3];
  logic [VERTEX_W-1:0] lo01;
  logic [VERTEX_W-1:0] hi01;
  logic [VERTEX_W-1:0] new_min;
  logic [VERTEX_W-1:0] new_max;
  logic [PW-1:0]       new_start;
  logic [PW-1:0]       pos_next;
  logic                close0_ok;
  logic                close1_ok;
  rng_t                rec0;
  rng_t                rec1;

  function automatic rng_t make_rec(
    input logic [GW-1:0]       grp,
    input logic [VERTEX_W-1:0] vmin,
    input logic [VERTEX_W-1:0] vmax,
    input logic [PW-1:0]       first,
    input logic [PW-1:0]       last,
    input logic                ok,
    input logic                done
  );
    rng_t r;
    r = '0;
    if (ok) begin
      r.range_group  = GROUP_W'(grp);
      r.vertex_low   = vmin;
      r.vertex_end   = {1'b0, vmax} + VEND_W'(1);
      r.index_first  = INDEX_W'({2'b00, first} + {1'b0, first, 1'b0});
      r.index_end    = INDEX_W'({2'b00, last} + {1'b0, last, 1'b0});
      r.record_valid = 1'b1;
    end
    r.done_res = done;
    return r;
  endfunction

  assign g        = group_id[GW-1:0];
  assign changed  = segment_open && (g != open_group);
  assign cont     = segment_open && !changed;
  assign base_min = cont ? span_min : vertex_a;
  assign base_max = cont ? span_max : vertex_a;

  trgrt_lane u_lane_a (
    .vertex(vertex_a), .base_min(base_min), .base_max(base_max), .lo(lo[0]), .hi(hi[0])
  );
  trgrt_lane u_lane_b (
    .vertex(vertex_b), .base_min(base_min), .base_max(base_max), .lo(lo[1]), .hi(hi[1])
  );
  trgrt_lane u_lane_c (
    .vertex(vertex_c), .base_min(base_min), .base_max(base_max), .lo(lo[2]), .hi(hi[2])
  );

  assign lo01    = (lo[0] < lo[1]) ? lo[0] : lo[1];
  assign hi01    = (hi[0] > hi[1]) ? hi[0] : hi[1];
  assign new_min = (lo01 < lo[2]) ? lo01 : lo[2];
  assign new_max = (hi01 > hi[2]) ? hi01 : hi[2];

  assign new_start = cont ? segment_start : position;
  assign pos_next  = (position < POS_BOUND) ? position + PW'(1) : position;

  assign close0_ok = changed && !seen[open_group] && (span_max != span_min) &&
                     (position != segment_start);
  assign close1_ok = !seen[g] && (new_max != new_min) && (pos_next != new_start);

  assign rec0 = make_rec(open_group, span_min, span_max, segment_start, position,
                         close0_ok, 1'b0);
  assign rec1 = make_rec(g, new_min, new_max, new_start, pos_next, close1_ok, 1'b1);

  always_comb begin
    push.push_n = 2'd0;
    if (take) begin
      push.push_n = {1'b0, close0_ok} + {1'b0, mesh_end};
    end
    push.entry0 = close0_ok ? rec0 : rec1;
    push.entry1 = rec1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_group    <= '0;
      segment_open  <= 1'b0;
      segment_start <= '0;
      position      <= '0;
      span_min      <= '0;
      span_max      <= '0;
      seen          <= '0;
    end else if (take) begin
      if (mesh_end) begin
        open_group    <= '0;
        segment_open  <= 1'b0;
        segment_start <= '0;
        position      <= '0;
        span_min      <= '0;
        span_max      <= '0;
        seen          <= '0;
      end else begin
        open_group    <= g;
        segment_open  <= 1'b1;
        segment_start <= new_start;
        position      <= pos_next;
        span_min      <= new_min;
        span_max      <= new_max;
        if (close0_ok) begin
          seen[open_group] <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/trgrt_outq.sv */
`default_nettype none

module trgrt_outq import trgrt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_ready,
  output rng_t  out_data
);

  rng_t       entries [4];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] count;
  logic       pop;

  assign room      = (count <= 3'd2);
  assign out_valid = (count != 3'd0);
  assign out_data  = entries[rptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push.push_n != 2'd0) begin
      entries[wptr] <= push.entry0;
    end
    if (push.push_n == 2'd2) begin
      entries[wptr + 2'd1] <= push.entry1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + push.push_n;
      rptr  <= rptr + {1'b0, pop};
      count <= count + {1'b0, push.push_n} - {2'b00, pop};
    end
  end

endmodule

`default_nettype wire

/* hdl/triangle_group_range_tracker_top.sv */
`default_nettype none

// Takes one triangle per clock cycle while tris.ready is high and closes a polygon-group
// segment whenever the group changes or the mesh ends, giving its vertex and index-buffer
// spans as a range record; groups that already have a record and segments with a single
// vertex value are suppressed, and the last triangle always yields a result marked done.
// A triangle enters each cycle that tris.ready is high; its results are written into a
// four-entry result queue that drains one transfer per cycle while ranges.ready is high,
// and ready drops while fewer than two queue slots are free, since a triangle that both
// changes group and ends the mesh can give two results. The three vertices are compared
// in three parallel lanes whose outputs are merged into the running minimum and maximum.
module triangle_group_range_tracker_top import trgrt_pkg::*; #(
  parameter int GROUP_BITS     = 8,
  parameter int TRI_COUNT_BITS = 24
) (
  input  logic clk,
  input  logic rst,
  trgrt_tri_if.sink   tris,
  trgrt_rng_if.source ranges
);

  logic  take;
  logic  room;
  push_t push;
  rng_t  out_data;

  assign tris.ready = room && !rst;
  assign take       = tris.valid && tris.ready;

  trgrt_track #(
    .GROUP_BITS    (GROUP_BITS),
    .TRI_COUNT_BITS(TRI_COUNT_BITS)
  ) u_track (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .group_id(tris.group_id),
    .vertex_a(tris.vertex_a),
    .vertex_b(tris.vertex_b),
    .vertex_c(tris.vertex_c),
    .mesh_end(tris.mesh_end),
    .push    (push)
  );

  trgrt_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .out_valid(ranges.valid),
    .out_ready(ranges.ready),
    .out_data (out_data)
  );

  assign ranges.range_group  = out_data.range_group;
  assign ranges.vertex_low   = out_data.vertex_low;
  assign ranges.vertex_end   = out_data.vertex_end;
  assign ranges.index_first  = out_data.index_first;
  assign ranges.index_end    = out_data.index_end;
  assign ranges.record_valid = out_data.record_valid;
  assign ranges.done_res     = out_data.done_res;

endmodule

`default_nettype wire
